### rtl/frst_pkg.sv
// Shared types and constants for the frame reassembly slot tracker.
package frst_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [31:0] SMALL_FRAME_CAP = 32'h0000ffff;
  localparam logic [31:0] LARGE_FRAME_MARK = 32'hffff0000;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_SKIPPED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [31:0] frame;
    logic [63:0] ftime;
    logic [15:0] position;
    logic [15:0] expected;
    logic [15:0] received;
    logic [15:0] range;
  } slot_t;

  // Per-cycle command from the controller to every cell.
  typedef struct packed {
    logic clear_all;
    logic clear_one;
    logic [SLOT_W-1:0] clear_idx;
    logic load;
    logic [SLOT_W-1:0] load_idx;
    slot_t load_val;
    logic add;
    logic [SLOT_W-1:0] add_idx;
    logic [15:0] add_cnt;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVICT,
    S_COUNT,
    S_DELIVER,
    S_STATUS
  } state_t;

endpackage

### rtl/frame_reassembly_slot_tracker_unit.sv
// Top level of the frame reassembly slot tracker: controller plus a chain of slot cells.
//
// channel  | signals                                   | handshake
// cfg      | cfg_we, cfg_wdata                         | written when cfg_we high
// in       | sender_position .. frame_time             | beat when start && !busy
// out      | item_kind .. last_item                    | beat when done high
//
// Paths from accept to next accept: foreign sender, a status beat; no slot, a status beat;
// joining packet, counted, plus its records when it completes; new frame, loaded into a free
// slot first; eviction, victim records before the load. At most SLOT_COUNT + 1 records.
// The slot search runs as one pass along the cell chain each cycle.
// Reset clears all slots at once; a frame counter wrap clears them on accept.
// Results cannot be stalled; one beat per done cycle.
module frame_reassembly_slot_tracker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic [15:0] sender_position,
  input  logic [31:0] frame_number,
  input  logic [15:0] frame_total_points,
  input  logic [15:0] packet_point_count,
  input  logic [15:0] range_mode,
  input  logic [63:0] frame_time,
  output logic        done,
  output logic        item_kind,
  output logic [1:0]  packet_status,
  output logic [31:0] out_frame,
  output logic [63:0] out_time,
  output logic [15:0] out_position,
  output logic [15:0] out_expected,
  output logic [15:0] out_received,
  output logic [15:0] out_range,
  output logic        frame_complete,
  output logic        last_item
);
  import frst_pkg::*;

  cell_cmd_t cmd;
  logic [31:0] key_frame, lim_frame;
  logic [SLOT_W-1:0] excl_idx, rd_idx, tgt_idx;
  logic excl_en;
  slot_t slots [SLOT_COUNT];

  logic              m_c [SLOT_COUNT+1];
  logic [SLOT_W-1:0] mi_c [SLOT_COUNT+1];
  logic              f_c [SLOT_COUNT+1];
  logic [SLOT_W-1:0] fi_c [SLOT_COUNT+1];
  logic              o_c [SLOT_COUNT+1];
  logic [SLOT_W-1:0] oi_c [SLOT_COUNT+1];
  logic [31:0]       of_c [SLOT_COUNT+1];
  logic              d_c [SLOT_COUNT+1];
  logic [SLOT_W-1:0] di_c [SLOT_COUNT+1];
  logic [31:0]       df_c [SLOT_COUNT+1];

  assign m_c[0] = 1'b0;
  assign mi_c[0] = '0;
  assign f_c[0] = 1'b0;
  assign fi_c[0] = '0;
  assign o_c[0] = 1'b0;
  assign oi_c[0] = '0;
  assign of_c[0] = '0;
  assign d_c[0] = 1'b0;
  assign di_c[0] = '0;
  assign df_c[0] = '0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    frst_cell u_cell (
      .clk, .rst,
      .idx(SLOT_W'(g)),
      .cmd, .key_frame, .lim_frame, .excl_idx, .excl_en,
      .match_in(m_c[g]), .match_idx_in(mi_c[g]),
      .free_in(f_c[g]), .free_idx_in(fi_c[g]),
      .old_in(o_c[g]), .old_idx_in(oi_c[g]), .old_frame_in(of_c[g]),
      .del_in(d_c[g]), .del_idx_in(di_c[g]), .del_frame_in(df_c[g]),
      .match_out(m_c[g+1]), .match_idx_out(mi_c[g+1]),
      .free_out(f_c[g+1]), .free_idx_out(fi_c[g+1]),
      .old_out(o_c[g+1]), .old_idx_out(oi_c[g+1]), .old_frame_out(of_c[g+1]),
      .del_out(d_c[g+1]), .del_idx_out(di_c[g+1]), .del_frame_out(df_c[g+1]),
      .slot(slots[g])
    );
  end

  frst_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .cfg_we, .cfg_wdata,
    .sender_position, .frame_number, .frame_total_points,
    .packet_point_count, .range_mode, .frame_time,
    .cmd, .key_frame, .lim_frame, .excl_idx, .excl_en,
    .match_f(m_c[SLOT_COUNT]), .match_idx(mi_c[SLOT_COUNT]),
    .free_f(f_c[SLOT_COUNT]), .free_idx(fi_c[SLOT_COUNT]),
    .old_f(o_c[SLOT_COUNT]), .old_idx(oi_c[SLOT_COUNT]),
    .del_f(d_c[SLOT_COUNT]), .del_idx(di_c[SLOT_COUNT]),
    .sel_slot(slots[rd_idx]), .tgt_slot(slots[tgt_idx]),
    .rd_idx, .tgt_idx,
    .done, .item_kind, .packet_status, .out_frame, .out_time, .out_position,
    .out_expected, .out_received, .out_range, .frame_complete, .last_item
  );

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst) !busy |-> !done)
    else $error("result beat while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (done && last_item) |=> !done)
    else $error("beat after last item");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (done && item_kind) |-> last_item)
    else $error("status beat not last");

endmodule

### rtl/frst_cell.sv
// One slot cell: stores a slot and folds it into the running search that passes along the chain.
module frst_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [frst_pkg::SLOT_W-1:0] idx,
  input  frst_pkg::cell_cmd_t        cmd,
  input  logic [31:0]                key_frame,
  input  logic [31:0]                lim_frame,
  input  logic [frst_pkg::SLOT_W-1:0] excl_idx,
  input  logic                       excl_en,
  // chain in
  input  logic                       match_in,
  input  logic [frst_pkg::SLOT_W-1:0] match_idx_in,
  input  logic                       free_in,
  input  logic [frst_pkg::SLOT_W-1:0] free_idx_in,
  input  logic                       old_in,
  input  logic [frst_pkg::SLOT_W-1:0] old_idx_in,
  input  logic [31:0]                old_frame_in,
  input  logic                       del_in,
  input  logic [frst_pkg::SLOT_W-1:0] del_idx_in,
  input  logic [31:0]                del_frame_in,
  // chain out
  output logic                       match_out,
  output logic [frst_pkg::SLOT_W-1:0] match_idx_out,
  output logic                       free_out,
  output logic [frst_pkg::SLOT_W-1:0] free_idx_out,
  output logic                       old_out,
  output logic [frst_pkg::SLOT_W-1:0] old_idx_out,
  output logic [31:0]                old_frame_out,
  output logic                       del_out,
  output logic [frst_pkg::SLOT_W-1:0] del_idx_out,
  output logic [31:0]                del_frame_out,
  output frst_pkg::slot_t            slot
);
  import frst_pkg::*;

  logic in_use;
  logic is_match, is_old, is_del;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all || (cmd.clear_one && cmd.clear_idx == idx)) begin
      slot <= '0;
    end else if (cmd.load && cmd.load_idx == idx) begin
      slot <= cmd.load_val;
    end else if (cmd.add && cmd.add_idx == idx) begin
      slot.received <= slot.received + cmd.add_cnt;
    end
  end

  assign in_use = (slot.expected != 16'd0);
  assign is_match = in_use && slot.frame == key_frame;
  // eviction victim: any slot (free ones included) below the key frame
  assign is_old = slot.frame < key_frame;
  // delivery candidate: in use, below limit, not the finishing slot
  assign is_del = in_use && slot.frame < lim_frame && !(excl_en && excl_idx == idx);

  always_comb begin
    match_out = match_in;
    match_idx_out = match_idx_in;
    if (!match_in && is_match) begin
      match_out = 1'b1;
      match_idx_out = idx;
    end
    free_out = free_in;
    free_idx_out = free_idx_in;
    if (!in_use) begin
      free_out = 1'b1;
      free_idx_out = idx;
    end
    old_out = old_in;
    old_idx_out = old_idx_in;
    old_frame_out = old_frame_in;
    if (is_old && (!old_in || slot.frame < old_frame_in)) begin
      old_out = 1'b1;
      old_idx_out = idx;
      old_frame_out = slot.frame;
    end
    del_out = del_in;
    del_idx_out = del_idx_in;
    del_frame_out = del_frame_in;
    if (is_del && (!del_in || slot.frame < del_frame_in)) begin
      del_out = 1'b1;
      del_idx_out = idx;
      del_frame_out = slot.frame;
    end
  end

endmodule

### rtl/frst_ctrl.sv
// Sequencer: binding, wrap detect, slot choice, counting and delivery.
module frst_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cfg_we,
  input  logic [15:0]                cfg_wdata,
  input  logic [15:0]                sender_position,
  input  logic [31:0]                frame_number,
  input  logic [15:0]                frame_total_points,
  input  logic [15:0]                packet_point_count,
  input  logic [15:0]                range_mode,
  input  logic [63:0]                frame_time,
  output frst_pkg::cell_cmd_t        cmd,
  output logic [31:0]                key_frame,
  output logic [31:0]                lim_frame,
  output logic [frst_pkg::SLOT_W-1:0] excl_idx,
  output logic                       excl_en,
  input  logic                       match_f,
  input  logic [frst_pkg::SLOT_W-1:0] match_idx,
  input  logic                       free_f,
  input  logic [frst_pkg::SLOT_W-1:0] free_idx,
  input  logic                       old_f,
  input  logic [frst_pkg::SLOT_W-1:0] old_idx,
  input  logic                       del_f,
  input  logic [frst_pkg::SLOT_W-1:0] del_idx,
  input  frst_pkg::slot_t            sel_slot,
  input  frst_pkg::slot_t            tgt_slot,
  output logic [frst_pkg::SLOT_W-1:0] rd_idx,
  output logic [frst_pkg::SLOT_W-1:0] tgt_idx,
  output logic                       done,
  output logic                       item_kind,
  output logic [1:0]                 packet_status,
  output logic [31:0]                out_frame,
  output logic [63:0]                out_time,
  output logic [15:0]                out_position,
  output logic [15:0]                out_expected,
  output logic [15:0]                out_received,
  output logic [15:0]                out_range,
  output logic                       frame_complete,
  output logic                       last_item
);
  import frst_pkg::*;

  state_t state, state_next;
  logic [15:0] code;
  logic [15:0] bound;
  logic [31:0] newest;
  logic [15:0] r_sender, r_total, r_count, r_range;
  logic [31:0] r_frame;
  logic [63:0] r_time;
  logic [SLOT_W-1:0] tgt;
  logic [1:0] status;
  logic after_evict; // delivering a victim, then load the new frame
  logic any_out;

  logic wrap, bound_unk, foreign;
  logic [16:0] sum;
  logic emit_rec;
  logic evict_tail;

  assign busy = (state != S_IDLE);
  assign wrap = (frame_number < SMALL_FRAME_CAP) && (newest > LARGE_FRAME_MARK);
  assign bound_unk = wrap ? 1'b1 : (bound == code);
  assign foreign = !bound_unk && (bound != sender_position);
  assign key_frame = r_frame;
  assign tgt_idx = tgt;
  assign sum = {1'b0, tgt_slot.received} + {1'b0, r_count};
  assign excl_idx = tgt;
  assign excl_en = 1'b1;
  // after an eviction the victim itself is the limit; otherwise the finished slot
  assign lim_frame = tgt_slot.frame;
  assign rd_idx = del_f ? del_idx : tgt;
  // reloaded frame completes on this very packet
  assign evict_tail = (r_total != 16'd0) && (r_count == r_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      code <= 16'hffff;
    end else if (cfg_we) begin
      code <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bound <= 16'hffff;
      newest <= '0;
      status <= ST_SKIPPED;
      after_evict <= 1'b0;
      any_out <= 1'b0;
      tgt <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            r_sender <= sender_position;
            r_frame <= frame_number;
            r_total <= frame_total_points;
            r_count <= packet_point_count;
            r_range <= range_mode;
            r_time <= frame_time;
            status <= ST_SKIPPED;
            any_out <= 1'b0;
            after_evict <= 1'b0;
            if (wrap) begin
              newest <= '0;
              bound <= code;
            end
            if (!foreign) begin
              if (bound_unk && sender_position != code) bound <= sender_position;
              if ((wrap ? 32'd0 : newest) < frame_number) newest <= frame_number;
            end
          end
        end
        S_SCAN: begin
          if (match_f) tgt <= match_idx;
          else if (free_f) tgt <= free_idx;
          else if (old_f) begin
            tgt <= old_idx;
            after_evict <= 1'b1;
            // the new frame starts empty, so its status is known before the victim goes out
            if (r_total == 16'd0) status <= ST_SKIPPED;
            else if (r_count > r_total) status <= ST_OVERFLOW;
            else status <= ST_ACCEPTED;
          end
        end
        S_DELIVER: begin
          any_out <= 1'b1;
          if (!del_f && after_evict) after_evict <= 1'b0;
        end
        S_COUNT: begin
          if (r_total != 16'd0) begin
            status <= (sum > {1'b0, tgt_slot.expected}) ? ST_OVERFLOW : ST_ACCEPTED;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:
        if (start) state_next = (foreign && !wrap) ? S_STATUS : S_SCAN;
      S_SCAN:
        if (match_f) state_next = S_COUNT;
        else if (free_f) state_next = S_EVICT;
        else if (old_f) state_next = S_DELIVER;
        else state_next = S_STATUS;
      S_EVICT: state_next = S_COUNT;
      S_DELIVER:
        if (!del_f) state_next = after_evict ? S_EVICT : S_IDLE;
      S_COUNT:
        if (r_total != 16'd0 && sum <= {1'b0, tgt_slot.expected}
            && sum[15:0] == tgt_slot.expected)
          state_next = S_DELIVER;
        else if (any_out) state_next = S_IDLE;
        else state_next = S_STATUS;
      S_STATUS: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // last record of a delivery run ends the step unless the reloaded frame completes too
  assign emit_rec = (state == S_DELIVER);

  always_comb begin
    cmd = '0;
    cmd.clear_all = (state == S_IDLE) && start && wrap;
    cmd.load_val.frame = r_frame;
    cmd.load_val.ftime = r_time;
    cmd.load_val.position = r_sender;
    cmd.load_val.expected = r_total;
    cmd.load_val.received = 16'd0;
    cmd.load_val.range = r_range;
    cmd.load = (state == S_EVICT);
    cmd.load_idx = tgt;
    cmd.add_idx = tgt;
    cmd.add_cnt = r_count;
    cmd.add = (state == S_COUNT) && r_total != 16'd0 && sum <= {1'b0, tgt_slot.expected};
    cmd.clear_one = emit_rec;
    cmd.clear_idx = rd_idx;
  end

  always_comb begin
    done = 1'b0;
    item_kind = KIND_RECORD;
    packet_status = status;
    out_frame = '0;
    out_time = '0;
    out_position = '0;
    out_expected = '0;
    out_received = '0;
    out_range = '0;
    frame_complete = 1'b0;
    last_item = 1'b0;
    if (emit_rec) begin
      done = 1'b1;
      out_frame = sel_slot.frame;
      out_time = sel_slot.ftime;
      out_position = sel_slot.position;
      out_expected = sel_slot.expected;
      out_received = sel_slot.received;
      out_range = sel_slot.range;
      frame_complete = (sel_slot.received == sel_slot.expected);
      last_item = !del_f && !(after_evict && evict_tail);
    end else if (state == S_STATUS) begin
      done = 1'b1;
      item_kind = KIND_STATUS;
      last_item = 1'b1;
    end
  end

endmodule
